>>> design/gpiq_pkg.sv
// Shared types, constants and codes of the gamepad input qualifier.
package gpiq_pkg;

  localparam int unsigned GPIQ_BUTTON_COUNT = 14;
  localparam int unsigned GPIQ_BUTTON_MAX   = 16;
  localparam int unsigned GPIQ_FIFO_DEPTH   = 4;
  localparam int unsigned GPIQ_CFG_AW       = 2;
  localparam int unsigned GPIQ_CFG_DW       = 15;

  typedef enum logic [GPIQ_CFG_AW-1:0] {
    REG_LEFT_DEAD_ZONE  = 2'd0,
    REG_RIGHT_DEAD_ZONE = 2'd1,
    REG_LEFT_THRESHOLD  = 2'd2,
    REG_RIGHT_THRESHOLD = 2'd3
  } gpiq_reg_e;

  typedef enum logic [3:0] {
    EV_LEFT_MOVE      = 4'd0,
    EV_LEFT_REPEAT    = 4'd1,
    EV_RIGHT_MOVE     = 4'd2,
    EV_RIGHT_REPEAT   = 4'd3,
    EV_BUTTON_DOWN    = 4'd4,
    EV_BUTTON_UP      = 4'd5,
    EV_BUTTON_REPEAT  = 4'd6,
    EV_LTRIG_PULL     = 4'd7,
    EV_LTRIG_REPEAT   = 4'd8,
    EV_RTRIG_PULL     = 4'd9,
    EV_RTRIG_REPEAT   = 4'd10,
    EV_DISCONNECT     = 4'd11,
    EV_RECONNECT      = 4'd12
  } gpiq_kind_e;

  typedef struct packed {
    logic               pad_connected;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [15:0]        button_word;
    logic [7:0]         left_pull;
    logic [7:0]         right_pull;
  } gpiq_poll_t;

  typedef struct packed {
    logic [3:0]         event_kind;
    logic [3:0]         button_index;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [7:0]         trigger_value;
    logic               last_event;
  } gpiq_event_t;

  // Classified poll handed from the front end to the event sequencer.
  typedef struct packed {
    logic                       lmove;
    logic                       lrep;
    logic signed [15:0]         lx;
    logic signed [15:0]         ly;
    logic                       rmove;
    logic                       rrep;
    logic signed [15:0]         rx;
    logic signed [15:0]         ry;
    logic [GPIQ_BUTTON_MAX-1:0] btn_prev;
    logic [GPIQ_BUTTON_MAX-1:0] btn_cur;
    logic                       ltpull;
    logic                       ltrep;
    logic [7:0]                 ltv;
    logic                       rtpull;
    logic                       rtrep;
    logic [7:0]                 rtv;
    logic                       conn_ev;
    logic                       conn_up;
  } gpiq_job_t;

endpackage

>>> design/gamepad_input_qualifier.sv
// Top level of the gamepad input qualifier.
// An accepted poll is written to the queue, then loaded into the sequencer's job and pending registers.
// The event sequencer emits one word per cycle while the output is not stalled; a poll gives
// as many words as it has events (up to BUTTON_COUNT + 5), and none when it has no events.
// The queue of FIFO_DEPTH polls lets new polls be taken while words are still drained.
// Reset clears the stored poll, the configuration registers and the queue at once.
module gamepad_input_qualifier import gpiq_pkg::*; #(
  parameter int unsigned BUTTON_COUNT = GPIQ_BUTTON_COUNT,
  parameter int unsigned FIFO_DEPTH   = GPIQ_FIFO_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [GPIQ_CFG_AW-1:0] cfg_addr_i,
  input  logic [GPIQ_CFG_DW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  gpiq_poll_t             in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output gpiq_event_t            out_data_o
);

  logic      push, full, pop, head_valid;
  gpiq_job_t job, head;

  gpiq_front #(.BUTTON_COUNT(BUTTON_COUNT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job)
  );

  gpiq_job_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head)
  );

  gpiq_back #(.BUTTON_COUNT(BUTTON_COUNT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> design/gpiq_front.sv
// Front end: configuration registers, deadzone and threshold, comparison with the stored poll.
module gpiq_front import gpiq_pkg::*; #(
  parameter int unsigned BUTTON_COUNT = GPIQ_BUTTON_COUNT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [GPIQ_CFG_AW-1:0] cfg_addr_i,
  input  logic [GPIQ_CFG_DW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  gpiq_poll_t             in_data_i,
  input  logic                   full_i,
  output logic                   push_o,
  output gpiq_job_t              job_o
);

  function automatic logic [15:0] button_mask(input int unsigned idx);
    logic [15:0] m;
    case (idx)
      0:       m = 16'h1000;
      1:       m = 16'h2000;
      2:       m = 16'h4000;
      3:       m = 16'h8000;
      4:       m = 16'h0020;
      5:       m = 16'h0010;
      6:       m = 16'h0001;
      7:       m = 16'h0002;
      8:       m = 16'h0004;
      9:       m = 16'h0008;
      10:      m = 16'h0100;
      11:      m = 16'h0200;
      12:      m = 16'h0040;
      13:      m = 16'h0080;
      14:      m = 16'h0400;
      15:      m = 16'h0800;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  function automatic logic in_zone(input logic signed [15:0] x, input logic signed [15:0] y,
                                   input logic [14:0] dz);
    logic signed [16:0] d;
    logic signed [16:0] xs;
    logic signed [16:0] ys;
    d  = $signed({2'b00, dz});
    xs = 17'(x);
    ys = 17'(y);
    return (xs < d) && (xs > -d) && (ys < d) && (ys > -d);
  endfunction

  logic [14:0]        left_dz_q, right_dz_q;
  logic [7:0]         left_thr_q, right_thr_q;
  logic               was_conn_q;
  logic signed [15:0] lsx_q, lsy_q, rsx_q, rsy_q;
  logic [15:0]        held_q;
  logic [7:0]         ltl_q, rtl_q;

  logic               conn;
  logic signed [15:0] lx, ly, rx, ry;
  logic [7:0]         ltv, rtv;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign conn       = in_data_i.pad_connected;

  always_comb begin
    lx  = in_zone(in_data_i.left_x, in_data_i.left_y, left_dz_q) ? 16'sd0 : in_data_i.left_x;
    ly  = in_zone(in_data_i.left_x, in_data_i.left_y, left_dz_q) ? 16'sd0 : in_data_i.left_y;
    rx  = in_zone(in_data_i.right_x, in_data_i.right_y, right_dz_q) ? 16'sd0 : in_data_i.right_x;
    ry  = in_zone(in_data_i.right_x, in_data_i.right_y, right_dz_q) ? 16'sd0 : in_data_i.right_y;
    ltv = (in_data_i.left_pull <= left_thr_q) ? 8'd0 : in_data_i.left_pull;
    rtv = (in_data_i.right_pull <= right_thr_q) ? 8'd0 : in_data_i.right_pull;
  end

  always_comb begin
    job_o        = '0;
    job_o.lx     = lx;
    job_o.ly     = ly;
    job_o.rx     = rx;
    job_o.ry     = ry;
    job_o.ltv    = ltv;
    job_o.rtv    = rtv;
    job_o.lmove  = conn && (lx != lsx_q || ly != lsy_q);
    job_o.lrep   = conn && !(lx != lsx_q || ly != lsy_q) && (lx != 16'sd0 || ly != 16'sd0);
    job_o.rmove  = conn && (rx != rsx_q || ry != rsy_q);
    job_o.rrep   = conn && !(rx != rsx_q || ry != rsy_q) && (rx != 16'sd0 || ry != 16'sd0);
    job_o.ltpull = conn && (ltv != ltl_q);
    job_o.ltrep  = conn && (ltv == ltl_q) && (ltv != 8'd0);
    job_o.rtpull = conn && (rtv != rtl_q);
    job_o.rtrep  = conn && (rtv == rtl_q) && (rtv != 8'd0);
    for (int unsigned i = 0; i < GPIQ_BUTTON_MAX; i++) begin
      if (i < BUTTON_COUNT) begin
        job_o.btn_prev[i] = conn && (|(held_q & button_mask(i)));
        job_o.btn_cur[i]  = conn && (|(in_data_i.button_word & button_mask(i)));
      end
    end
    job_o.conn_ev = conn != was_conn_q;
    job_o.conn_up = conn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q   <= '0;
      right_dz_q  <= '0;
      left_thr_q  <= '0;
      right_thr_q <= '0;
    end else if (cfg_we_i) begin
      case (gpiq_reg_e'(cfg_addr_i))
        REG_LEFT_DEAD_ZONE:  left_dz_q   <= cfg_wdata_i;
        REG_RIGHT_DEAD_ZONE: right_dz_q  <= cfg_wdata_i;
        REG_LEFT_THRESHOLD:  left_thr_q  <= cfg_wdata_i[7:0];
        REG_RIGHT_THRESHOLD: right_thr_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_conn_q <= 1'b0;
      lsx_q      <= '0;
      lsy_q      <= '0;
      rsx_q      <= '0;
      rsy_q      <= '0;
      held_q     <= '0;
      ltl_q      <= '0;
      rtl_q      <= '0;
    end else if (push_o) begin
      was_conn_q <= conn;
      if (conn) begin
        lsx_q  <= lx;
        lsy_q  <= ly;
        rsx_q  <= rx;
        rsy_q  <= ry;
        held_q <= in_data_i.button_word;
        ltl_q  <= ltv;
        rtl_q  <= rtv;
      end
    end
  end

endmodule

>>> design/gpiq_job_fifo.sv
// Short queue of classified polls between the front end and the event sequencer.
module gpiq_job_fifo import gpiq_pkg::*; #(
  parameter int unsigned DEPTH = GPIQ_FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  gpiq_job_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      head_valid_o,
  output gpiq_job_t head_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gpiq_job_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o       = count_q == CW'(DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> design/gpiq_back.sv
// Event sequencer: turns one classified poll into its ordered event words.
module gpiq_back import gpiq_pkg::*; #(
  parameter int unsigned BUTTON_COUNT = GPIQ_BUTTON_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  gpiq_job_t   head_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output gpiq_event_t out_data_o
);

  localparam int unsigned NSLOT   = BUTTON_COUNT + 5;
  localparam int unsigned SW      = $clog2(NSLOT);
  localparam int unsigned SLOT_LT = BUTTON_COUNT + 2;
  localparam int unsigned SLOT_RT = BUTTON_COUNT + 3;
  localparam int unsigned SLOT_CN = BUTTON_COUNT + 4;

  gpiq_job_t      job_q;
  logic [NSLOT-1:0] pend_q, pend_rest, head_mask;
  logic [SW-1:0]  sel;
  logic           adv, ld;
  logic           out_valid_q;
  gpiq_event_t    out_q, ev;
  logic [3:0]     bidx;
  logic           bp, bc;

  always_comb begin
    head_mask    = '0;
    head_mask[0] = head_data_i.lmove || head_data_i.lrep;
    head_mask[1] = head_data_i.rmove || head_data_i.rrep;
    for (int unsigned k = 0; k < BUTTON_COUNT; k++) begin
      head_mask[2 + k] = head_data_i.btn_prev[BUTTON_COUNT - 1 - k]
                      || head_data_i.btn_cur[BUTTON_COUNT - 1 - k];
    end
    head_mask[SLOT_LT] = head_data_i.ltpull || head_data_i.ltrep;
    head_mask[SLOT_RT] = head_data_i.rtpull || head_data_i.rtrep;
    head_mask[SLOT_CN] = head_data_i.conn_ev;
  end

  always_comb begin
    sel = '0;
    for (int s = NSLOT - 1; s >= 0; s--) begin
      if (pend_q[s]) begin
        sel = SW'(s);
      end
    end
    pend_rest = pend_q;
    pend_rest[sel] = 1'b0;
  end

  assign adv   = (pend_q != '0) && (!out_valid_q || out_ready_i);
  assign ld    = head_valid_i && ((pend_q == '0) || (adv && pend_rest == '0));
  assign pop_o = ld;

  assign bidx = 4'(int'(BUTTON_COUNT) + 1 - int'(sel));
  assign bp   = job_q.btn_prev[bidx];
  assign bc   = job_q.btn_cur[bidx];

  always_comb begin
    ev            = '0;
    ev.last_event = pend_rest == '0;
    if (sel == SW'(0)) begin
      ev.event_kind = job_q.lmove ? EV_LEFT_MOVE : EV_LEFT_REPEAT;
      ev.stick_x    = job_q.lx;
      ev.stick_y    = job_q.ly;
    end else if (sel == SW'(1)) begin
      ev.event_kind = job_q.rmove ? EV_RIGHT_MOVE : EV_RIGHT_REPEAT;
      ev.stick_x    = job_q.rx;
      ev.stick_y    = job_q.ry;
    end else if (sel == SW'(SLOT_LT)) begin
      ev.event_kind    = job_q.ltpull ? EV_LTRIG_PULL : EV_LTRIG_REPEAT;
      ev.trigger_value = job_q.ltv;
    end else if (sel == SW'(SLOT_RT)) begin
      ev.event_kind    = job_q.rtpull ? EV_RTRIG_PULL : EV_RTRIG_REPEAT;
      ev.trigger_value = job_q.rtv;
    end else if (sel == SW'(SLOT_CN)) begin
      ev.event_kind = job_q.conn_up ? EV_RECONNECT : EV_DISCONNECT;
    end else begin
      ev.button_index = bidx;
      if (!bp && bc) begin
        ev.event_kind = EV_BUTTON_DOWN;
      end else if (bp && !bc) begin
        ev.event_kind = EV_BUTTON_UP;
      end else begin
        ev.event_kind = EV_BUTTON_REPEAT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      job_q <= head_data_i;
    end
    if (adv) begin
      out_q <= ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld) begin
        pend_q <= head_mask;
      end else if (adv) begin
        pend_q <= pend_rest;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_adv_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("Emitted word did not reach the output register.");

  a_pending_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && pend_q != '0) |=> $stable(pend_q))
    else $error("Pending events changed while the output was stalled.");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("Queue popped while empty.");

  a_load_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |-> (pend_q == '0 || (adv && $countones(pend_q) == 1)))
    else $error("New poll loaded before the previous one was finished.");

endmodule
